FILE: hw/rtl/wad_pkg.sv
package wad_pkg;

  localparam int MaxRuns    = 64;
  localparam int MaxFactors = 16;
  localparam int StoreDepth = MaxRuns * MaxFactors;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CoordW     = 16;
  localparam int RunW       = 7;
  localparam int FacW       = 5;
  localparam int IdxW       = $clog2(MaxRuns);
  localparam int KW         = $clog2(MaxFactors);
  localparam int ProdW      = 64;
  localparam int TermW      = 34;
  localparam int N2W        = 2 * RunW;
  localparam int OutW       = 41;

  localparam logic [ProdW-1:0] Q32One      = 64'h0000_0001_0000_0000;
  localparam logic [ProdW-1:0] Q32Half     = 64'h0000_0000_8000_0000;
  localparam logic [TermW-1:0] ThreeHalves = 34'h1_8000_0000;
  localparam logic [TermW-1:0] FourThirds  = 34'd5726623061;
  localparam logic [ProdW-1:0] OutMax      = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [ProdW-1:0] OutMinMag   = 64'h0000_0100_0000_0000;

  typedef enum logic {
    RegNumRuns    = 1'b0,
    RegNumFactors = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             load;
    logic             rd;
    logic [AddrW-1:0] addr_i;
    logic [AddrW-1:0] addr_j;
    logic             term;
    logic             pow;
    logic             mlo;
    logic             mhi;
    logic             acc;
    logic             prod_init;
    logic             sum_clr;
    logic             sum_add;
    logic             div_start;
    logic             fin;
    logic [RunW-1:0]  runs;
  } cmd_t;

endpackage

FILE: hw/rtl/wad_div.sv
module wad_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wad_pkg::ProdW-1:0] dividend_i,
  input  logic [wad_pkg::N2W-1:0]   divisor_i,
  output logic [wad_pkg::ProdW-1:0] quo_o,
  output logic [wad_pkg::N2W-1:0]   rem_o,
  output logic                      done_o
);

  logic [wad_pkg::ProdW-1:0] quo_q;
  logic [wad_pkg::N2W-1:0]   rem_q;
  logic [wad_pkg::N2W-1:0]   dsr_q;
  logic [5:0]                cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [wad_pkg::N2W:0]     trial;
  logic                      fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, quo_q[wad_pkg::ProdW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[wad_pkg::N2W-1:0] - dsr_q : trial[wad_pkg::N2W-1:0];
      quo_q <= {quo_q[wad_pkg::ProdW-2:0], fits};
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/wad_dpath.sv
module wad_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wad_pkg::cmd_t              cmd_i,
  input  logic [wad_pkg::CoordW-1:0] coord_i,
  input  logic                       last_i,
  output logic                       div_done_o,
  output logic [wad_pkg::OutW-1:0]   discrepancy_o
);

  logic [wad_pkg::CoordW-1:0] mem [wad_pkg::StoreDepth];
  logic [wad_pkg::AddrW-1:0]  load_cnt_q;
  logic [wad_pkg::CoordW-1:0] xi_q, xj_q;
  logic [wad_pkg::TermW-1:0]  term_q;
  logic [wad_pkg::ProdW+1:0]  pl_q, ph_q;
  logic [wad_pkg::ProdW-1:0]  prod_q, psum_q;
  logic [wad_pkg::OutW-1:0]   result_q;

  logic [wad_pkg::CoordW-1:0] diff;
  logic [2*wad_pkg::CoordW-1:0] sq;
  logic [wad_pkg::TermW-1:0]  term_d;
  logic [97:0]                full;
  logic [wad_pkg::ProdW-1:0]  prod_d;
  logic [wad_pkg::ProdW:0]    sum_ext;
  logic [wad_pkg::N2W-1:0]    n2;
  logic [wad_pkg::ProdW-1:0]  quo;
  logic [wad_pkg::N2W-1:0]    rem;
  logic [wad_pkg::ProdW-1:0]  mean, dpos, dneg, dneg_sat, negv;
  logic [wad_pkg::OutW-1:0]   result_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (cmd_i.load) begin
      load_cnt_q <= last_i ? '0 : load_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[load_cnt_q] <= coord_i;
    end
    if (cmd_i.rd) begin
      xi_q <= mem[cmd_i.addr_i];
      xj_q <= mem[cmd_i.addr_j];
    end
  end

  // Factor term 3/2 - |d| + d^2 in Q.32, or 4/3 when pow is set; with 16 fraction bits d^2 is exact.
  assign diff   = (xi_q >= xj_q) ? xi_q - xj_q : xj_q - xi_q;
  assign sq     = {16'h0000, diff} * {16'h0000, diff};
  assign term_d = cmd_i.pow ? wad_pkg::FourThirds
                : wad_pkg::ThreeHalves - {2'b00, diff, 16'h0000} + {2'b00, sq};

  assign full    = {ph_q, 32'h0} + {32'h0, pl_q} + {34'h0, wad_pkg::Q32Half};
  assign prod_d  = (full[97:96] != 2'b00) ? '1 : full[95:32];
  assign sum_ext = {1'b0, psum_q} + {1'b0, prod_q};
  assign n2      = {7'h00, cmd_i.runs} * {7'h00, cmd_i.runs};

  always_ff @(posedge clk_i) begin
    if (cmd_i.term) begin
      term_q <= term_d;
    end
    if (cmd_i.mlo) begin
      pl_q <= {34'h0, prod_q[31:0]} * {32'h0, term_q};
    end
    if (cmd_i.mhi) begin
      ph_q <= {34'h0, prod_q[63:32]} * {32'h0, term_q};
    end
    if (cmd_i.prod_init) begin
      prod_q <= wad_pkg::Q32One;
    end else if (cmd_i.acc) begin
      prod_q <= prod_d;
    end
    if (cmd_i.sum_clr) begin
      psum_q <= '0;
    end else if (cmd_i.sum_add) begin
      psum_q <= sum_ext[wad_pkg::ProdW] ? '1 : sum_ext[wad_pkg::ProdW-1:0];
    end
    if (cmd_i.fin) begin
      result_q <= result_d;
    end
  end

  wad_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(psum_q),
    .divisor_i (n2),
    .quo_o     (quo),
    .rem_o     (rem),
    .done_o    (div_done_o)
  );

  // The power (4/3)^s sits in prod_q when the final step runs.
  always_comb begin
    mean     = quo + {63'h0, ({rem, 1'b0} >= {1'b0, n2})};
    dpos     = mean - prod_q;
    dneg     = prod_q - mean;
    dneg_sat = (dneg > wad_pkg::OutMinMag) ? wad_pkg::OutMinMag : dneg;
    negv     = 64'h0 - dneg_sat;
    if (mean >= prod_q) begin
      result_d = (dpos > wad_pkg::OutMax) ? wad_pkg::OutMax[wad_pkg::OutW-1:0]
                                          : dpos[wad_pkg::OutW-1:0];
    end else begin
      result_d = negv[wad_pkg::OutW-1:0];
    end
  end

  assign discrepancy_o = result_q;

endmodule

FILE: hw/rtl/wad_ctrl.sv
module wad_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     last_i,
  input  logic [wad_pkg::RunW-1:0] num_runs_i,
  input  logic [wad_pkg::FacW-1:0] num_factors_i,
  input  logic                     div_done_i,
  output wad_pkg::cmd_t            cmd_o,
  output logic                     busy,
  output logic                     done_o
);

  typedef enum logic [3:0] {
    SIdle, SRd, STerm, SMlo, SMhi, SAcc, SSum, SDivGo, SDiv, SFin
  } state_e;

  state_e                    state_q;
  logic [wad_pkg::IdxW-1:0]  i_q, j_q;
  logic [wad_pkg::KW-1:0]    k_q;
  logic [wad_pkg::AddrW-1:0] base_i_q, base_j_q;
  logic                      pow_q;
  logic                      done_q;

  logic [wad_pkg::RunW-1:0]  runs_c;
  logic [wad_pkg::FacW-1:0]  fac_c;
  logic                      i_last, j_last, k_last, accept;

  assign runs_c = (num_runs_i < 7'd2) ? 7'd2
                : (num_runs_i > 7'(wad_pkg::MaxRuns)) ? 7'(wad_pkg::MaxRuns) : num_runs_i;
  assign fac_c  = (num_factors_i < 5'd1) ? 5'd1
                : (num_factors_i > 5'(wad_pkg::MaxFactors)) ? 5'(wad_pkg::MaxFactors)
                : num_factors_i;

  assign i_last = {1'b0, i_q} == runs_c - 7'd1;
  assign j_last = {1'b0, j_q} == runs_c - 7'd1;
  assign k_last = {1'b0, k_q} == fac_c - 5'd1;
  assign busy   = state_q != SIdle;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      base_i_q <= '0;
      base_j_q <= '0;
      pow_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (accept && last_i) begin
            i_q      <= '0;
            j_q      <= '0;
            k_q      <= '0;
            base_i_q <= '0;
            base_j_q <= '0;
            pow_q    <= 1'b0;
            state_q  <= SRd;
          end
        end
        SRd:   state_q <= STerm;
        STerm: state_q <= SMlo;
        SMlo:  state_q <= SMhi;
        SMhi:  state_q <= SAcc;
        SAcc: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= pow_q ? SFin : SSum;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= pow_q ? STerm : SRd;
          end
        end
        SSum: begin
          if (j_last) begin
            j_q      <= '0;
            base_j_q <= '0;
            if (i_last) begin
              state_q <= SDivGo;
            end else begin
              i_q      <= i_q + 1'b1;
              base_i_q <= base_i_q + wad_pkg::AddrW'(fac_c);
              state_q  <= SRd;
            end
          end else begin
            j_q      <= j_q + 1'b1;
            base_j_q <= base_j_q + wad_pkg::AddrW'(fac_c);
            state_q  <= SRd;
          end
        end
        SDivGo: state_q <= SDiv;
        SDiv: begin
          if (div_done_i) begin
            pow_q   <= 1'b1;
            k_q     <= '0;
            state_q <= STerm;
          end
        end
        SFin: begin
          done_q  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.rd        = state_q == SRd;
    cmd_o.addr_i    = base_i_q + wad_pkg::AddrW'(k_q);
    cmd_o.addr_j    = base_j_q + wad_pkg::AddrW'(k_q);
    cmd_o.term      = state_q == STerm;
    cmd_o.pow       = pow_q;
    cmd_o.mlo       = state_q == SMlo;
    cmd_o.mhi       = state_q == SMhi;
    cmd_o.acc       = state_q == SAcc;
    cmd_o.prod_init = (accept && last_i) || (state_q == SSum)
                    || (state_q == SDiv && div_done_i);
    cmd_o.sum_clr   = accept && last_i;
    cmd_o.sum_add   = state_q == SSum;
    cmd_o.div_start = state_q == SDivGo;
    cmd_o.fin       = state_q == SFin;
    cmd_o.runs      = runs_c;
  end

  assign done_o = done_q;

endmodule

FILE: hw/rtl/wraparound_l2_discrepancy.sv
// Channel  | Signals                       | Direction
// ---------+-------------------------------+----------
// input    | start, busy, coord_i, last_i  | in (busy out)
// result   | done_o, discrepancy_o         | out
// config   | psel, penable, pwrite, paddr, | APB slave
//          | pwdata, prdata, pready        |
//
// Coordinates load one per cycle while busy is low, into a single store
// with two read ports. After the beat marked last, each factor of each
// pair is multiplied in two halves, low then high, and the mean uses a
// one-bit-per-cycle divider. busy stays high for the whole evaluation.
// Reset clears control state and the registers to two runs and one factor.
// The result is shown for one cycle with done_o; the receiver cannot stall.
module wraparound_l2_discrepancy (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [wad_pkg::CoordW-1:0] coord_i,
  input  logic                       last_i,
  output logic                       done_o,
  output logic [wad_pkg::OutW-1:0]   discrepancy_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [wad_pkg::RunW-1:0] num_runs_q;
  logic [wad_pkg::FacW-1:0] num_factors_q;
  wad_pkg::cmd_t            cmd;
  logic                     div_done;
  logic                     wr_en;
  wad_pkg::reg_idx_e        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = wad_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_runs_q    <= 7'd2;
      num_factors_q <= 5'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        wad_pkg::RegNumRuns:    num_runs_q    <= pwdata[wad_pkg::RunW-1:0];
        wad_pkg::RegNumFactors: num_factors_q <= pwdata[wad_pkg::FacW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wad_pkg::RegNumRuns:    prdata = {25'h0, num_runs_q};
      wad_pkg::RegNumFactors: prdata = {27'h0, num_factors_q};
      default:                prdata = '0;
    endcase
  end

  wad_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .last_i       (last_i),
    .num_runs_i   (num_runs_q),
    .num_factors_i(num_factors_q),
    .div_done_i   (div_done),
    .cmd_o        (cmd),
    .busy         (busy),
    .done_o       (done_o)
  );

  wad_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .coord_i      (coord_i),
    .last_i       (last_i),
    .div_done_o   (div_done),
    .discrepancy_o(discrepancy_o)
  );

  a_last_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("last beat did not start an evaluation");

  a_plain_beat_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_i) |=> !busy && !done_o)
    else $error("plain beat left the block busy or gave a result");

  a_result_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_result_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result without a finished evaluation");

endmodule
